// ===== rtl/sce_pkg.sv =====
package sce_pkg;

  // field widths of the stream words
  localparam int unsigned CoordPortW = 16;
  localparam int unsigned ValueW     = 32;
  localparam int unsigned SlotW      = 8;
  localparam int unsigned CountOutW  = 9;
  localparam int unsigned StatusW    = 2;

  typedef logic [StatusW-1:0] status_t;

  // result status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // access commands
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // configuration register indexes
  localparam logic CFG_ROW_COUNT    = 1'b0;
  localparam logic CFG_COLUMN_COUNT = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } seq_state_t;

  // one result word before packing
  typedef struct packed {
    logic signed [ValueW-1:0] read_value;
    logic                     was_present;
    logic [SlotW-1:0]         slot;
    logic [CountOutW-1:0]     entry_count;
    status_t                  status;
  } res_t;

  // request from the sequencer to the entry store
  typedef struct packed {
    logic rd_en;
    logic key_we;
    logic val_we;
  } store_ctl_t;

endpackage

// ===== rtl/sce_store.sv =====
module sce_store #(
  parameter int unsigned ENTRY_CAPACITY = 256,
  parameter int unsigned KEY_W          = 32
) (
  input  logic                                    clk,
  input  sce_pkg::store_ctl_t                     ctl,
  input  logic [$clog2(ENTRY_CAPACITY)-1:0]       wr_addr,
  input  logic [KEY_W-1:0]                        wr_key,
  input  logic signed [sce_pkg::ValueW-1:0]       wr_val,
  input  logic [$clog2(ENTRY_CAPACITY)-1:0]       rd_addr,
  output logic [KEY_W-1:0]                        rd_key,
  output logic signed [sce_pkg::ValueW-1:0]       rd_val
);
  import sce_pkg::*;

  logic [KEY_W-1:0]         key_mem [ENTRY_CAPACITY];
  logic signed [ValueW-1:0] val_mem [ENTRY_CAPACITY];
  logic [KEY_W-1:0]         rd_key_r;
  logic signed [ValueW-1:0] rd_val_r;

  // coordinate pair memory, one write port
  always_ff @(posedge clk) begin
    if (ctl.key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
  end

  // value memory, one write port
  always_ff @(posedge clk) begin
    if (ctl.val_we) begin
      val_mem[wr_addr] <= wr_val;
    end
  end

  // registered read of both memories at one address
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_key_r <= key_mem[rd_addr];
      rd_val_r <= val_mem[rd_addr];
    end
  end

  assign rd_key = rd_key_r;
  assign rd_val = rd_val_r;

endmodule

// ===== rtl/sce_seq.sv =====
module sce_seq #(
  parameter int unsigned ENTRY_CAPACITY = 256,
  parameter int unsigned INDEX_BITS     = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic                                       in_cmd,
  input  logic [sce_pkg::CoordPortW-1:0]             in_row,
  input  logic [sce_pkg::CoordPortW-1:0]             in_col,
  input  logic signed [sce_pkg::ValueW-1:0]          in_wval,
  input  logic [sce_pkg::CoordPortW-1:0]             row_count,
  input  logic [sce_pkg::CoordPortW-1:0]             column_count,
  output logic                                       res_valid,
  input  logic                                       res_take,
  output sce_pkg::res_t                              res,
  output logic [$clog2(ENTRY_CAPACITY+1)-1:0]        entry_count
);
  import sce_pkg::*;

  localparam int unsigned AddrW  = $clog2(ENTRY_CAPACITY);
  localparam int unsigned CountW = $clog2(ENTRY_CAPACITY + 1);
  localparam int unsigned CoordW = (INDEX_BITS < CoordPortW) ? INDEX_BITS : CoordPortW;
  localparam int unsigned KeyW   = 2 * CoordW;

  seq_state_t               state_r, state_nxt;
  logic [CountW-1:0]        count_r, count_nxt;
  logic [CountW-1:0]        scan_r, scan_nxt;
  logic                     pend_r, pend_nxt;
  logic [AddrW-1:0]         cmp_r, cmp_nxt;
  logic                     cmd_r, cmd_nxt;
  logic [KeyW-1:0]          key_r, key_nxt;
  logic signed [ValueW-1:0] wval_r, wval_nxt;
  res_t                     res_r, res_nxt;

  store_ctl_t               ctl;
  logic [AddrW-1:0]         wr_addr;
  logic signed [ValueW-1:0] wr_val;
  logic [AddrW-1:0]         rd_addr;
  logic [KeyW-1:0]          rd_key;
  logic signed [ValueW-1:0] rd_val;

  logic [CoordPortW-1:0]    row_m;
  logic [CoordPortW-1:0]    col_m;
  logic                     out_of_range;
  logic                     match;
  logic signed [ValueW-1:0] new_val;

  sce_store #(
    .ENTRY_CAPACITY (ENTRY_CAPACITY),
    .KEY_W          (KeyW)
  ) u_store (
    .clk     (clk),
    .ctl     (ctl),
    .wr_addr (wr_addr),
    .wr_key  (key_r),
    .wr_val  (wr_val),
    .rd_addr (rd_addr),
    .rd_key  (rd_key),
    .rd_val  (rd_val)
  );

  // coordinates are kept within the index width
  assign row_m        = CoordPortW'(in_row[CoordW-1:0]);
  assign col_m        = CoordPortW'(in_col[CoordW-1:0]);
  assign out_of_range = (row_m >= row_count) || (column_count <= col_m);

  // compare unit, one stored pair per cycle
  assign match   = pend_r && (rd_key == key_r);
  assign new_val = (cmd_r == CMD_WRITE) ? wval_r : '0;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // held access and result
  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
    cmp_r  <= cmp_nxt;
    cmd_r  <= cmd_nxt;
    key_r  <= key_nxt;
    wval_r <= wval_nxt;
    res_r  <= res_nxt;
  end

  // sequencer: range check, linear search, then hit result, append on a miss or full status
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    scan_nxt   = scan_r;
    pend_nxt   = pend_r;
    cmp_nxt    = cmp_r;
    cmd_nxt    = cmd_r;
    key_nxt    = key_r;
    wval_nxt   = wval_r;
    res_nxt    = res_r;
    ctl        = '0;
    wr_addr    = cmp_r;
    wr_val     = wval_r;
    rd_addr    = scan_r[AddrW-1:0];
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt  = in_cmd;
          key_nxt  = {col_m[CoordW-1:0], row_m[CoordW-1:0]};
          wval_nxt = in_wval;
          scan_nxt = '0;
          pend_nxt = 1'b0;
          if (out_of_range) begin
            res_nxt   = '{read_value: '0, was_present: 1'b0, slot: '0,
                          entry_count: CountOutW'(count_r), status: ST_RANGE};
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        pend_nxt = 1'b0;
        if (match) begin
          // hit: a write replaces the value in place
          ctl.val_we = (cmd_r == CMD_WRITE);
          wr_addr    = cmp_r;
          wr_val     = wval_r;
          res_nxt    = '{read_value: (cmd_r == CMD_WRITE) ? wval_r : rd_val,
                         was_present: 1'b1, slot: SlotW'(cmp_r),
                         entry_count: CountOutW'(count_r), status: ST_OK};
          state_nxt  = S_RESP;
        end else if (scan_r != count_r) begin
          // fetch the next stored pair
          ctl.rd_en = 1'b1;
          pend_nxt  = 1'b1;
          cmp_nxt   = scan_r[AddrW-1:0];
          scan_nxt  = CountW'(scan_r + 1'b1);
        end else if (count_r == CountW'(ENTRY_CAPACITY)) begin
          res_nxt   = '{read_value: '0, was_present: 1'b0, slot: '0,
                        entry_count: CountOutW'(count_r), status: ST_FULL};
          state_nxt = S_RESP;
        end else begin
          // miss: append a new entry
          ctl.key_we = 1'b1;
          ctl.val_we = 1'b1;
          wr_addr    = count_r[AddrW-1:0];
          wr_val     = new_val;
          count_nxt  = CountW'(count_r + 1'b1);
          res_nxt    = '{read_value: new_val, was_present: 1'b0,
                         slot: SlotW'(count_r),
                         entry_count: CountOutW'(CountW'(count_r + 1'b1)),
                         status: ST_OK};
          state_nxt  = S_RESP;
        end
      end
      S_RESP: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res         = res_r;
  assign entry_count = count_r;

endmodule

// ===== rtl/sparse_coordinate_entry_table.sv =====
// An access runs from accept through a range check and a linear search of the stored
// entries to an update, append or full status and the result word; an out-of-range access
// skips the search. One access at a time: a new word is taken only after the previous
// result has left the sequencer. The linear search reads one stored coordinate pair per cycle.
// Reset (rst_n low, synchronous): table empty, row and column counts 1, no word pending.
module sparse_coordinate_entry_table #(
  parameter int unsigned ENTRY_CAPACITY = 256,
  parameter int unsigned INDEX_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: row [15:0], column [31:16], write_value [63:32]
  input  logic [63:0] in_tdata,
  // in_tuser: command [0]
  input  logic        in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: read_value [31:0], was_present [32], slot [40:33], entry_count [49:41]
  output logic [55:0] out_tdata,
  // out_tuser: status [1:0]
  output logic [1:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import sce_pkg::*;

  localparam int unsigned CountW = $clog2(ENTRY_CAPACITY + 1);

  logic [CoordPortW-1:0] row_count_r;
  logic [CoordPortW-1:0] column_count_r;
  logic                  out_valid_r, out_valid_nxt;
  res_t                  out_res_r;
  res_t                  seq_res;
  logic                  seq_res_valid;
  logic                  res_take;
  logic [CountW-1:0]     seq_count;

  sce_seq #(
    .ENTRY_CAPACITY (ENTRY_CAPACITY),
    .INDEX_BITS     (INDEX_BITS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_cmd       (in_tuser),
    .in_row       (in_tdata[15:0]),
    .in_col       (in_tdata[31:16]),
    .in_wval      (in_tdata[63:32]),
    .row_count    (row_count_r),
    .column_count (column_count_r),
    .res_valid    (seq_res_valid),
    .res_take     (res_take),
    .res          (seq_res),
    .entry_count  (seq_count)
  );

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= 16'd1;
      column_count_r <= 16'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ROW_COUNT:    row_count_r    <= cfg_data;
        CFG_COLUMN_COUNT: column_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // output word register, loads when empty or being drained
  assign res_take      = seq_res_valid && (!out_valid_r || out_tready);
  assign out_valid_nxt = res_take || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= seq_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {6'd0, out_res_r.entry_count, out_res_r.slot,
                       out_res_r.was_present, out_res_r.read_value};

  // checks on the sequencer and the result word
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seq_count <= CountW'(ENTRY_CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    seq_count != $past(seq_count) |-> seq_count == CountW'($past(seq_count) + 1'b1))
    else $error("entry count moved by more than one");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("new word taken while an access is in progress");

  a_range_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_RANGE || out_tuser == ST_FULL) |->
      out_tdata[40:0] == 41'd0)
    else $error("flagged access returned entry data");

endmodule

// ===== sim/tb_sparse_coordinate_entry_table.sv =====
module tb_sparse_coordinate_entry_table;
  import sce_pkg::*;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned CoordBits  = 16;

  // bit positions inside the result word
  localparam int unsigned PresentBit = ValueW;
  localparam int unsigned SlotLo     = ValueW + 1;
  localparam int unsigned CountLo    = SlotLo + SlotW;
  localparam int unsigned PadLo      = CountLo + CountOutW;

  typedef struct {
    logic        cmd;
    logic [15:0] row;
    logic [15:0] col;
    logic [31:0] wval;
    bit          hold_off;
  } access_t;

  typedef struct {
    logic [15:0] row;
    logic [15:0] col;
  } coord_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic [63:0] in_tdata;
  logic        in_tuser;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  // pending accesses and predicted result words
  access_t     access_q[$];
  res_t        result_q[$];
  coord_t      coord_pool[$];

  // predictor copy of the table and the limits
  logic [15:0]        row_tab[TableDepth];
  logic [15:0]        col_tab[TableDepth];
  logic signed [31:0] val_tab[TableDepth];
  int unsigned        fill_n   = 0;
  logic [15:0]        rows_lim = 16'd1;
  logic [15:0]        cols_lim = 16'd1;

  // limits as the stimulus side last wrote them
  logic [15:0] cur_rows = 16'd1;
  logic [15:0] cur_cols = 16'd1;

  int unsigned queued_n  = 0;
  int unsigned results_n = 0;
  int unsigned err_n     = 0;
  int unsigned send_gap  = 0;
  int unsigned recv_stall = 0;
  bit          idle_on   = 1'b1;
  bit          access_taken = 1'b0;

  sparse_coordinate_entry_table #(
    .ENTRY_CAPACITY (TableDepth),
    .INDEX_BITS     (CoordBits)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // gap length, mostly short and now and then long
  function automatic int unsigned rand_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // range check, search in insertion order, append on a miss, then read or write
  function automatic res_t lookup_entry(input logic cmd, input logic [15:0] r,
                                        input logic [15:0] c, input logic [31:0] wv);
    res_t res;
    int   hit;
    int   k;
    res = '0;
    hit = -1;
    if (r >= rows_lim || c >= cols_lim) begin
      res.entry_count = CountOutW'(fill_n);
      res.status      = ST_RANGE;
      return res;
    end
    for (k = 0; k < int'(fill_n); k++) begin
      if (hit < 0 && row_tab[k] == r && col_tab[k] == c) hit = k;
    end
    if (hit >= 0) begin
      if (cmd == CMD_WRITE) val_tab[hit] = wv;
      res.read_value  = val_tab[hit];
      res.was_present = 1'b1;
      res.slot        = SlotW'(hit);
      res.entry_count = CountOutW'(fill_n);
      res.status      = ST_OK;
    end else if (fill_n >= TableDepth) begin
      res.entry_count = CountOutW'(fill_n);
      res.status      = ST_FULL;
    end else begin
      row_tab[fill_n] = r;
      col_tab[fill_n] = c;
      val_tab[fill_n] = (cmd == CMD_WRITE) ? wv : 32'sd0;
      res.read_value  = val_tab[fill_n];
      res.slot        = SlotW'(fill_n);
      fill_n++;
      res.entry_count = CountOutW'(fill_n);
      res.status      = ST_OK;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h, expected %0h", what, got, want);
    err_n++;
  endtask

  // sample handshakes, predict and compare at the rising edge
  always @(posedge clk) begin
    res_t want;
    access_taken = rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ROW_COUNT) rows_lim = cfg_data;
        else cols_lim = cfg_data;
      end
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected word", 64'(out_tdata), '0);
        end else begin
          want = result_q.pop_front();
          results_n++;
          if (out_tdata[ValueW-1:0] !== want.read_value)
            report_mismatch("read_value", 64'(out_tdata[ValueW-1:0]), 64'(want.read_value));
          if (out_tdata[PresentBit] !== want.was_present)
            report_mismatch("was_present", 64'(out_tdata[PresentBit]), 64'(want.was_present));
          if (out_tdata[CountLo-1:SlotLo] !== want.slot)
            report_mismatch("slot", 64'(out_tdata[CountLo-1:SlotLo]), 64'(want.slot));
          if (out_tdata[PadLo-1:CountLo] !== want.entry_count)
            report_mismatch("entry_count", 64'(out_tdata[PadLo-1:CountLo]),
                            64'(want.entry_count));
          if (out_tdata[55:PadLo] !== '0)
            report_mismatch("padding", 64'(out_tdata[55:PadLo]), '0);
          if (out_tuser !== want.status)
            report_mismatch("status", 64'(out_tuser), 64'(want.status));
        end
      end
      if (access_taken)
        result_q.push_back(lookup_entry(in_tuser, in_tdata[15:0], in_tdata[31:16],
                                        in_tdata[63:32]));
    end
  end

  // access driver, fed from the pending queue
  always @(negedge clk) begin
    access_t a;
    logic    nxt_valid;
    nxt_valid = in_tvalid;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else if (!in_tvalid || access_taken) begin
      nxt_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (access_q.size() > 0 && !(access_q[0].hold_off && result_q.size() > 0)) begin
        a = access_q.pop_front();
        in_tdata  <= {a.wval, a.col, a.row};
        in_tuser  <= a.cmd;
        nxt_valid = 1'b1;
        send_gap  = idle_on ? rand_gap() : 0;
      end
    end
    in_tvalid <= nxt_valid;
  end

  // result receiver with random stalls
  always @(negedge clk) begin
    if (recv_stall > 0) begin
      out_tready <= 1'b0;
      recv_stall--;
    end else begin
      out_tready <= 1'b1;
      if (idle_on && $urandom_range(0, 99) < 30) recv_stall = rand_gap();
    end
  end

  task automatic push_access(input logic cmd, input logic [15:0] r, input logic [15:0] c,
                             input logic [31:0] wv, input bit hold);
    access_t a;
    a.cmd      = cmd;
    a.row      = r;
    a.col      = c;
    a.wval     = wv;
    a.hold_off = hold;
    access_q.push_back(a);
    queued_n++;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (results_n != queued_n);
  endtask

  task automatic cfg_write(input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_limits(input logic [15:0] rows, input logic [15:0] cols);
    cfg_write(CFG_ROW_COUNT, rows);
    cfg_write(CFG_COLUMN_COUNT, cols);
    cur_rows = rows;
    cur_cols = cols;
  endtask

  // random accesses: fresh pairs, revisited pairs and raw coordinates
  task automatic run_phase(input int unsigned n_items, input int unsigned fresh_pct);
    int unsigned p;
    int unsigned k;
    logic [15:0] r;
    logic [15:0] c;
    logic [31:0] v;
    coord_t      pc;
    for (k = 0; k < n_items; k++) begin
      p = $urandom_range(0, 99);
      if (p < 12) begin
        r = 16'($urandom());
        c = 16'($urandom());
      end else if (p < 12 + fresh_pct || coord_pool.size() == 0) begin
        r = 16'($urandom_range(0, int'(cur_rows) - 1));
        c = 16'($urandom_range(0, int'(cur_cols) - 1));
        pc.row = r;
        pc.col = c;
        coord_pool.push_back(pc);
      end else begin
        pc = coord_pool[$urandom_range(0, coord_pool.size() - 1)];
        r  = pc.row;
        c  = pc.col;
      end
      p = $urandom_range(0, 99);
      if (p < 8) v = 32'h7fff_ffff;
      else if (p < 16) v = 32'h8000_0000;
      else if (p < 20) v = 32'h0;
      else v = $urandom();
      push_access($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, r, c, v,
                  k == 0 || $urandom_range(0, 99) < 2);
    end
  endtask

  // stimulus sequence
  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_READ;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_ROW_COUNT;
    cfg_data   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset limits: only the pair (0,0) is in range
    push_access(CMD_READ,  16'd0, 16'd0, 32'h1234_5678, 1'b0);
    push_access(CMD_WRITE, 16'd0, 16'd0, 32'h7fff_ffff, 1'b0);
    push_access(CMD_READ,  16'd0, 16'd0, 32'h0, 1'b0);
    push_access(CMD_WRITE, 16'd0, 16'd0, 32'h8000_0000, 1'b0);
    push_access(CMD_READ,  16'd1, 16'd0, 32'h0, 1'b0);
    push_access(CMD_WRITE, 16'd0, 16'd1, 32'hffff_ffff, 1'b0);
    push_access(CMD_READ,  16'hffff, 16'hffff, 32'hffff_ffff, 1'b0);
    wait_drained();

    // widest limits
    set_limits(16'hffff, 16'hffff);
    push_access(CMD_WRITE, 16'hfffe, 16'hfffe, 32'hffff_ffff, 1'b0);
    push_access(CMD_READ,  16'hfffe, 16'hfffe, 32'h0, 1'b0);
    push_access(CMD_WRITE, 16'h0, 16'hfffe, 32'haaaa_aaaa, 1'b0);
    push_access(CMD_READ,  16'hfffe, 16'h0, 32'h5555_5555, 1'b0);
    push_access(CMD_WRITE, 16'hffff, 16'h0, 32'h1, 1'b0);
    push_access(CMD_WRITE, 16'h0, 16'hffff, 32'h1, 1'b0);
    push_access(CMD_WRITE, 16'h5555, 16'haaaa, 32'h5555_5555, 1'b0);
    push_access(CMD_WRITE, 16'haaaa, 16'h5555, 32'haaaa_aaaa, 1'b0);
    push_access(CMD_READ,  16'h5555, 16'haaaa, 32'h0, 1'b0);
    push_access(CMD_READ,  16'h0, 16'h0, 32'h0, 1'b1);
    wait_drained();

    // zero row count, then zero column count: everything out of range
    set_limits(16'h0, 16'hffff);
    push_access(CMD_READ, 16'h0, 16'h0, 32'h0, 1'b0);
    wait_drained();
    set_limits(16'hffff, 16'h0);
    push_access(CMD_WRITE, 16'h0, 16'h0, 32'h7fff_ffff, 1'b0);
    wait_drained();

    // random phases; together they fill the table
    idle_on = 1'b1;
    set_limits(16'hffff, 16'hffff);
    run_phase(180, 75);
    wait_drained();

    idle_on = 1'b0;
    set_limits(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
    run_phase(100, 40);
    wait_drained();

    idle_on = 1'b1;
    set_limits(16'd16, 16'd16);
    run_phase(100, 45);
    wait_drained();

    set_limits(16'd200, 16'd3);
    run_phase(80, 40);
    wait_drained();

    set_limits(16'd1, 16'hffff);
    run_phase(70, 40);
    wait_drained();

    set_limits(16'hffff, 16'd1);
    run_phase(70, 40);
    wait_drained();

    // let a stray word show up before the verdict
    repeat (2 * TableDepth) @(posedge clk);
    if (result_q.size() != 0) report_mismatch("missing word", 64'(result_q.size()), '0);
    if (err_n == 0) begin
      $display("sparse_coordinate_entry_table test passed");
    end else begin
      $display("sparse_coordinate_entry_table test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("sparse_coordinate_entry_table test failed");
    $finish;
  end

endmodule
